### hw/rtl/led_fx_pkg.sv
// Shared types, constants and helpers of the LED effect engine.
// Used by led_fx_div and led_effect_engine_top; depends on nothing else.

package led_fx_pkg;

	localparam int NUM_LEDS_DEF = 4;

	localparam int OUT_LED_W = 6;
	localparam int LEVEL_W   = 8;
	localparam int MODE_W    = 3;
	localparam int PERIOD_W  = 16;
	localparam int HALF_W    = PERIOD_W - 1;
	localparam int CFG_IDX_W = 2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DIM    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BREATH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PULSE  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_FLASH  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_BREATH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH  = 2'd2;

	localparam logic [PERIOD_W-1:0] BREATH_RST = 16'd4000;
	localparam logic [PERIOD_W-1:0] PULSE_RST  = 16'd1000;
	localparam logic [PERIOD_W-1:0] FLASH_RST  = 16'd500;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

	typedef struct packed {
		logic               opcode;
		logic [7:0]         led_index;
		logic [MODE_W-1:0]  mode;
		logic [LEVEL_W-1:0] dim_level;
	} req_t;

	typedef struct packed {
		logic [OUT_LED_W-1:0] out_led;
		logic [LEVEL_W-1:0]   brightness;
		logic [MODE_W-1:0]    out_mode;
		logic                 bad_index;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [LEVEL_W-1:0]  dim;
		logic [PERIOD_W-1:0] phase;
	} led_ent_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic [PERIOD_W-1:0] period_of(
		input logic [MODE_W-1:0]   m,
		input logic [PERIOD_W-1:0] breath,
		input logic [PERIOD_W-1:0] pulse,
		input logic [PERIOD_W-1:0] flash
	);
		logic [PERIOD_W-1:0] p;
		if (m == MODE_BREATH) begin
			p = breath;
		end else if (m == MODE_PULSE) begin
			p = pulse;
		end else begin
			p = flash;
		end
		return (p < PERIOD_MIN) ? PERIOD_MIN : p;
	endfunction

endpackage

### hw/rtl/led_fx_div.sv
// Iterative divider that computes (p * 255) / half, one quotient bit per cycle.
// Depends on led_fx_pkg.

module led_fx_div
	import led_fx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PERIOD_W-1:0] p,
	input  logic [HALF_W-1:0]   half,
	output logic [LEVEL_W-1:0]  quot,
	output div_sts_t            sts
);

	logic [HALF_W-1:0]    rem_q;
	logic [LEVEL_W-1:0]   qb_q;
	logic [HALF_W-1:0]    half_q;
	logic [2:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [23:0]          num;
	logic [HALF_W:0]      trial;
	logic                 ge;
	logic [HALF_W:0]      diff;

	assign num   = {p, 8'd0} - {8'd0, p};
	assign trial = {rem_q, qb_q[LEVEL_W-1]};
	assign ge    = trial >= {1'b0, half_q};
	assign diff  = trial - {1'b0, half_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			qb_q   <= '0;
			half_q <= '0;
		end else if (start) begin
			rem_q  <= num[22:8];
			qb_q   <= num[7:0];
			half_q <= half;
		end else if (busy_q) begin
			rem_q <= ge ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
			qb_q  <= {qb_q[LEVEL_W-2:0], ge};
		end
	end

	assign quot     = qb_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");

	a_quot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !start |=> $stable(qb_q))
		else $error("quotient changed while idle");

endmodule

### hw/rtl/led_effect_engine_top.sv
// Top level of the LED effect engine: request decode, LED state memory,
// phase sequencer and result register. Depends on led_fx_pkg and led_fx_div.
//
// Usage:
// A request on req_data is taken when req_valid is high and req_stall is low.
// A tick request (opcode 0) advances every animated LED by one millisecond and
// yields one result per LED, LED 0 first, with last set on the final one. A
// set-mode request (opcode 1) loads one LED's mode and dim level, clears its
// phase and yields one result; an index out of range yields one flagged
// result and changes nothing.
// Period registers are written on the cfg channel; cfg_ready is always high,
// and writes are expected only while the engine is idle.
// The engine takes one request at a time and holds req_stall high until its
// last result is in the result register. Each LED of a tick passes through
// the read, phase, level and emit states, and in breathing or pulse mode
// through a divide state after the level state, where the shared divider
// produces one quotient bit per cycle. A set-mode request passes through the
// set state and then on from the level state; a bad index goes to emit.
// When the receiver holds res_stall, the result waits in the result register
// and the sequencer waits before writing the next one.
// After reset all LEDs are off with phase zero and the periods are 4000, 1000
// and 500 ms; per-LED valid bits make the state memory read as cleared.

module led_effect_engine_top
	import led_fx_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data
);

	localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [LW-1:0] LED_LAST = LW'(NUM_LEDS - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SET   = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_PHASE = 7'b0001000,
		ST_LEVEL = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic                op_q;
	logic [7:0]          idx_q;
	logic [MODE_W-1:0]   req_mode_q;
	logic [LEVEL_W-1:0]  req_dim_q;
	logic [LW-1:0]       led_q;
	logic [MODE_W-1:0]   mode_q;
	logic [LEVEL_W-1:0]  dim_q;
	logic [PERIOD_W-1:0] phase_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                bad_q;
	logic                fall_q;
	logic [PERIOD_W-1:0] breath_q;
	logic [PERIOD_W-1:0] pulse_q;
	logic [PERIOD_W-1:0] flash_q;
	logic                res_valid_q;
	res_t                res_q;

	led_ent_t            led_mem [NUM_LEDS];
	logic [NUM_LEDS-1:0] vld_q;
	led_ent_t            rd_q;
	logic                rd_vld_q;

	logic                mem_we;
	logic [LW-1:0]       mem_wa;
	led_ent_t            mem_wd;

	logic                req_acc;
	logic                idx_ok;
	logic [MODE_W-1:0]   set_mode;
	led_ent_t            ent;
	logic                ent_anim;
	logic [PERIOD_W:0]   next_ph;
	logic [PERIOD_W-1:0] next_ph16;
	logic [PERIOD_W-1:0] per_ent;
	logic [PERIOD_W-1:0] per_lvl;
	logic [HALF_W-1:0]   half;
	logic                rising;
	logic [PERIOD_W-1:0] ph_diff;
	logic [PERIOD_W-1:0] div_p;
	logic                div_start;
	logic [LEVEL_W-1:0]  div_quot;
	div_sts_t            div_sts;
	logic                res_load;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign idx_ok   = {1'b0, idx_q} < 9'(NUM_LEDS);
	assign set_mode = (req_mode_q > MODE_FLASH) ? MODE_OFF : req_mode_q;

	assign ent      = rd_vld_q ? rd_q : '0;
	assign ent_anim = (ent.mode == MODE_BREATH) || (ent.mode == MODE_PULSE) ||
		(ent.mode == MODE_FLASH);
	assign per_ent  = period_of(ent.mode, breath_q, pulse_q, flash_q);
	assign next_ph  = {1'b0, ent.phase} + 17'd1;
	assign next_ph16 = (next_ph >= {1'b0, per_ent}) ? '0 : next_ph[PERIOD_W-1:0];

	assign per_lvl = period_of(mode_q, breath_q, pulse_q, flash_q);
	assign half    = per_lvl[PERIOD_W-1:1];
	assign rising  = phase_q < {1'b0, half};
	assign ph_diff = phase_q - {1'b0, half};
	assign div_p   = rising ? phase_q :
		((ph_diff > {1'b0, half}) ? {1'b0, half} : ph_diff);
	assign div_start = (state_q == ST_LEVEL) &&
		((mode_q == MODE_BREATH) || (mode_q == MODE_PULSE));

	assign res_load = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = led_q;
		mem_wd = '{mode: mode_q, dim: dim_q, phase: phase_q};
		if (state_q == ST_SET && idx_ok) begin
			mem_we = 1'b1;
			mem_wa = idx_q[LW-1:0];
			mem_wd = '{mode: set_mode, dim: req_dim_q, phase: '0};
		end else if (state_q == ST_PHASE && ent_anim) begin
			mem_we = 1'b1;
			mem_wd = '{mode: ent.mode, dim: ent.dim, phase: next_ph16};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			led_mem[mem_wa] <= mem_wd;
		end
		rd_q <= led_mem[led_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			rd_vld_q <= vld_q[led_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breath_q <= BREATH_RST;
			pulse_q  <= PULSE_RST;
			flash_q  <= FLASH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BREATH: breath_q <= cfg_data;
				CFG_PULSE:  pulse_q  <= cfg_data;
				CFG_FLASH:  flash_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	led_fx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.p      (div_p),
		.half   (half),
		.quot   (div_quot),
		.sts    (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			led_q   <= '0;
			op_q    <= OP_TICK;
			bad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						op_q  <= req_data.opcode;
						bad_q <= 1'b0;
						led_q <= '0;
						if (req_data.opcode == OP_SET) begin
							state_q <= ST_SET;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_SET: begin
					if (idx_ok) begin
						led_q   <= idx_q[LW-1:0];
						state_q <= ST_LEVEL;
					end else begin
						bad_q   <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_READ:  state_q <= ST_PHASE;
				ST_PHASE: state_q <= ST_LEVEL;
				ST_LEVEL: state_q <= div_start ? ST_DIV : ST_EMIT;
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_load) begin
						if (op_q == OP_TICK && led_q != LED_LAST) begin
							led_q   <= led_q + LW'(1);
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			idx_q      <= req_data.led_index;
			req_mode_q <= req_data.mode;
			req_dim_q  <= req_data.dim_level;
		end
		if (state_q == ST_SET) begin
			mode_q  <= idx_ok ? set_mode : MODE_OFF;
			dim_q   <= req_dim_q;
			phase_q <= '0;
			level_q <= '0;
		end
		if (state_q == ST_PHASE) begin
			mode_q  <= ent.mode;
			dim_q   <= ent.dim;
			phase_q <= ent_anim ? next_ph16 : ent.phase;
		end
		if (state_q == ST_LEVEL) begin
			fall_q <= !rising;
			case (mode_q) inside
				MODE_ON:   level_q <= LEVEL_FULL;
				MODE_DIM:  level_q <= dim_q;
				MODE_FLASH: level_q <= rising ? LEVEL_FULL : '0;
				MODE_BREATH, MODE_PULSE: level_q <= level_q;
				default:   level_q <= '0;
			endcase
		end
		if (state_q == ST_DIV && div_sts.done) begin
			level_q <= fall_q ? ~div_quot : div_quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.out_led    <= bad_q ? '0 : OUT_LED_W'(led_q);
			res_q.brightness <= level_q;
			res_q.out_mode   <= mode_q;
			res_q.bad_index  <= bad_q;
			res_q.last       <= (op_q == OP_SET) || (led_q == LED_LAST);
		end
	end

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res_data.bad_index || res_data.last))
		else $error("flagged result without last");

	a_off_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.out_mode == MODE_OFF |-> res_data.brightness == '0)
		else $error("LED in off mode shows light");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_sts.busy || div_sts.done)
		else $error("waiting on an idle divider");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && res_valid_q |-> !res_stall)
		else $error("result overwritten before it was taken");

endmodule
